// ===== src/nac_pkg.sv =====
// Shared types, constants and CRC-8 helper functions for the allocation table entry checker.
`default_nettype none

package nac_pkg;

   localparam int unsigned EntryBytes  = 8;
   localparam int unsigned AlignBytes  = 4;
   localparam int unsigned CrcMsgBits  = 8 * (EntryBytes - 1);

   localparam logic [7:0]  ErasedByte  = 8'hff;
   localparam logic [15:0] CloseId     = 16'hffff;
   localparam logic [7:0]  CrcPoly     = 8'h07;
   localparam logic [7:0]  CrcInit     = 8'hff;

   localparam int unsigned ReqDataBits = 80;
   localparam int unsigned RspDataBits = 72;
   localparam int unsigned RspUserBits = 4;

   typedef struct packed {
      logic        multipart_reject;
      logic        is_close_entry;
      logic        is_valid;
      logic        is_erased;
      logic [16:0] record_end;
      logic [15:0] record_length;
      logic [15:0] record_offset;
      logic [15:0] record_id;
   } nac_result_type;

   // One byte through the MSB-first CRC-8 register.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
      logic [7:0] crc;
      crc = crc_in ^ data;
      for (int b = 0; b < 8; b++) begin
         if (crc[7]) begin
            crc = {crc[6:0], 1'b0} ^ CrcPoly;
         end else begin
            crc = {crc[6:0], 1'b0};
         end
      end
      return crc;
   endfunction

   // CRC over the seven message bytes, byte 0 first.
   function automatic logic [7:0] crc8_msg(input logic [7:0] init,
                                           input logic [CrcMsgBits-1:0] msg);
      logic [7:0] crc;
      crc = init;
      for (int k = 0; k < int'(EntryBytes - 1); k++) begin
         crc = crc8_byte(crc, msg[8*k +: 8]);
      end
      return crc;
   endfunction

   // Contribution of a single message bit, with a zero starting value.
   function automatic logic [7:0] crc8_column(input int unsigned bit_idx);
      logic [CrcMsgBits-1:0] msg;
      msg = '0;
      msg[bit_idx] = 1'b1;
      return crc8_msg(8'h00, msg);
   endfunction

endpackage

`default_nettype wire

// ===== src/nvs_ate_entry_checker.sv =====
// Top level of the allocation table entry checker: input stage, checks and result register.
`default_nettype none

// Checks one eight-byte allocation table entry per item and returns its fields
// together with the erased, valid, close-entry and multipart flags. Each item
// passes an input register, one pass of combinational checking (a parallel
// CRC-8 network and the bounds compares) and a result register, so a result
// is offered once its item has passed the input register and the checks, and
// one item is taken every cycle while the result side keeps up. The two
// registers let an item be accepted while a finished result still waits to be taken.
// SECTOR_BYTES sets the sector size used for the close-slot bound and the close-entry gap.
module nvs_ate_entry_checker
   import nac_pkg::*;
#(
   parameter int unsigned SECTOR_BYTES = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // entry_word[63:0], entry_position[76:64], zero fill above
   input  wire logic [ReqDataBits-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // record_id[15:0], record_offset[31:16], record_length[47:32],
   // record_end[64:48], zero fill above
   output logic [RspDataBits-1:0]      rsp_tdata,
   // is_erased[0], is_valid[1], is_close_entry[2], multipart_reject[3]
   output logic [RspUserBits-1:0]      rsp_tuser
);

   logic           in_valid_ff, in_valid_in;
   logic [63:0]    in_word_ff;
   logic [12:0]    in_pos_ff;
   logic           out_valid_ff, out_valid_in;
   nac_result_type out_result_ff;
   nac_result_type check_result;
   logic           advance;
   logic           req_take;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_tdata[63:0];
         in_pos_ff  <= req_tdata[76:64];
      end
      if (advance && in_valid_ff) begin
         out_result_ff <= check_result;
      end
   end

   nac_check #(
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_check (
      .entry_word     (in_word_ff),
      .entry_position (in_pos_ff),
      .result         (check_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0000000,
                        out_result_ff.record_end,
                        out_result_ff.record_length,
                        out_result_ff.record_offset,
                        out_result_ff.record_id};
   assign rsp_tuser  = {out_result_ff.multipart_reject,
                        out_result_ff.is_close_entry,
                        out_result_ff.is_valid,
                        out_result_ff.is_erased};

`ifndef SYNTHESIS
   // An accepted item always occupies the input stage in the next cycle.
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted item did not enter the input stage");

   // A waiting result is never overwritten while the response side stalls it.
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_result_ff)))
      else $error("stalled result changed");

   // A close entry is always a valid entry.
   a_close_valid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_result_ff.is_close_entry) |-> out_result_ff.is_valid)
      else $error("close entry flagged without being valid");

   // Valid and multipart reject depend on opposite part byte tests.
   a_valid_multi: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_result_ff.is_valid && out_result_ff.multipart_reject))
      else $error("entry both valid and multipart");
`endif

endmodule

`default_nettype wire

// ===== src/nac_crc8.sv =====
// CRC-8 over the seven leading entry bytes, built as a parallel XOR network.
`default_nettype none

module nac_crc8
   import nac_pkg::*;
(
   input  wire logic [CrcMsgBits-1:0] msg,
   output logic      [7:0]            crc
);

   // The CRC is linear, so it is the check value of an all-zero message
   // combined with the contribution of every set message bit.
   localparam logic [7:0] CrcBase = crc8_msg(CrcInit, '0);

   logic [7:0] term [CrcMsgBits];

   for (genvar g = 0; g < int'(CrcMsgBits); g++) begin : g_col
      localparam logic [7:0] Column = crc8_column(g);
      assign term[g] = msg[g] ? Column : 8'h00;
   end

   always_comb begin
      crc = CrcBase;
      for (int i = 0; i < int'(CrcMsgBits); i++) begin
         crc = crc ^ term[i];
      end
   end

endmodule

`default_nettype wire

// ===== src/nac_check.sv =====
// Field split and validity checks for one allocation table entry.
`default_nettype none

module nac_check
   import nac_pkg::*;
#(
   parameter int unsigned SECTOR_BYTES = 4096
) (
   input  wire logic [63:0]    entry_word,
   input  wire logic [12:0]    entry_position,
   output nac_result_type      result
);

   localparam logic [16:0] CloseOff  = 17'(SECTOR_BYTES - EntryBytes);
   localparam logic [2:0]  SectorLow = 3'(SECTOR_BYTES % EntryBytes);

   logic [15:0] id;
   logic [15:0] off;
   logic [15:0] len;
   logic [7:0]  part;
   logic [7:0]  crc_stored;
   logic [7:0]  crc_calc;
   logic [16:0] span_end;
   logic        crc_ok;
   logic        part_erased;
   logic        valid;

   assign id         = entry_word[15:0];
   assign off        = entry_word[31:16];
   assign len        = entry_word[47:32];
   assign part       = entry_word[55:48];
   assign crc_stored = entry_word[63:56];

   nac_crc8 u_crc (
      .msg (entry_word[CrcMsgBits-1:0]),
      .crc (crc_calc)
   );

   assign span_end    = {1'b0, off} + {1'b0, len};
   assign crc_ok      = (crc_calc == crc_stored);
   assign part_erased = (part == ErasedByte);

   // Alignment is a power of two, so only the low offset bits matter.
   assign valid = part_erased && crc_ok &&
                  (off[$clog2(AlignBytes)-1:0] == '0) &&
                  (span_end < CloseOff) &&
                  (span_end <= {4'b0000, entry_position});

   always_comb begin
      result.record_id        = id;
      result.record_offset    = off;
      result.record_length    = len;
      result.record_end       = span_end;
      result.is_erased        = &entry_word;
      result.is_valid         = valid;
      // The gap to the sector end is a multiple of eight exactly when the
      // low three bits of the offset match those of the sector size.
      result.is_close_entry   = valid && (id == CloseId) && (len == '0) &&
                                (off[2:0] == SectorLow);
      result.multipart_reject = !part_erased && crc_ok;
   end

endmodule

`default_nettype wire
